// ----- rtl/core/lls_pkg.sv -----
// Shared types, constants and helper functions for the line-of-sight lock solver.
`default_nettype none
package lls_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W = $clog2(CORDIC_STEPS);

  localparam int DW = 48;
  localparam int ZW = 27;
  localparam int CW = 36;
  localparam int TW = 34;
  localparam int MA_W = 48;
  localparam int MB_W = 32;
  localparam int PW = MA_W + MB_W;
  localparam int MCNT_W = $clog2(MB_W);
  localparam int ADDR_W = 5;

  localparam logic signed [PW-1:0] RND30 = {{(PW-30){1'b0}}, 1'b1, 29'b0};
  localparam logic signed [PW-1:0] RND16 = {{(PW-16){1'b0}}, 1'b1, 15'b0};

  localparam logic signed [DW-1:0] INV_GAIN_Q30 = 48'sd652032874;
  localparam logic signed [MB_W-1:0] INV_GAIN_Q16 = 32'sd39797;
  localparam logic signed [ZW-1:0] Z_HALF_TURN = 27'sd11796480;

  localparam logic signed [16:0] A_TURN = 17'sd23040;
  localparam logic signed [16:0] A_HALF = 17'sd11520;
  localparam logic signed [16:0] A_QUARTER = 17'sd5760;

  localparam logic signed [17:0] P_TURN = 18'sd23040;
  localparam logic signed [17:0] P_HALF = 18'sd11520;

  localparam logic signed [TW:0] TGT_MAX_X = 35'sd8589934591;
  localparam logic signed [TW:0] TGT_MIN_X = -35'sd8589934592;

  localparam logic [2:0] REG_FWD = 3'd0;
  localparam logic [2:0] REG_DOWN = 3'd1;
  localparam logic [2:0] REG_MINR = 3'd2;
  localparam logic [2:0] REG_TUP = 3'd3;
  localparam logic [2:0] REG_TLO = 3'd4;

  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_TRACK = 2'd1,
    OP_DISABLE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_HEAD,
    ST_MUL_FS,
    ST_MUL_FC,
    ST_ROT_TILT,
    ST_ROT_AIM,
    ST_MUL_HZ,
    ST_MUL_E,
    ST_MUL_S,
    ST_MUL_U,
    ST_VEC_H,
    ST_MAG_H,
    ST_VEC_T,
    ST_MAG_T,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] down;
    logic [15:0] min_range;
    logic signed [13:0] tilt_hi;
    logic signed [13:0] tilt_lo;
  } cfg_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic flip;
  } rot_arg_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0: v = 27'sd2949120;
      5'd1: v = 27'sd1740967;
      5'd2: v = 27'sd919879;
      5'd3: v = 27'sd466945;
      5'd4: v = 27'sd234379;
      5'd5: v = 27'sd117304;
      5'd6: v = 27'sd58666;
      5'd7: v = 27'sd29335;
      5'd8: v = 27'sd14668;
      5'd9: v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Fold an angle in 1/64 degree into +-90 degrees, CORDIC units.
  function automatic rot_arg_t reduce_angle(input logic signed [16:0] a);
    logic signed [16:0] r;
    rot_arg_t res;
    r = a;
    res.flip = 1'b0;
    if (r < 0) r = r + A_TURN;
    if (r >= A_TURN) r = r - A_TURN;
    if (r >= A_TURN) r = r - A_TURN;
    if (r >= A_HALF) r = r - A_TURN;
    if (r > A_QUARTER) begin
      r = r - A_HALF;
      res.flip = 1'b1;
    end else if (r < -A_QUARTER) begin
      r = r + A_HALF;
      res.flip = 1'b1;
    end
    res.z = ZW'(r) <<< 10;
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/los_lock_pointing_solver.sv -----
// Line-of-sight lock solver top level: sequencer, lock state and stream ports.
// Input transactions on s_* carry the op in s_tuser and platform pose, camera angles
// and lock distance in s_tdata. Each transaction yields exactly one output
// transaction on m_* with pan, tilt and range in m_tdata and updated/lock flags in
// m_tuser. Registers on the APB port must be written only while the block is idle;
// the block itself does not enforce this. One shared CORDIC unit and one bit-serial
// multiplier do all the arithmetic under the sequencer.
// Track or no-op with the lock held: 3 CORDIC passes and 4 products.
// Set lock adds 2 passes and 4 products.
// Disable, or track or no-op without a lock: 1 pass and 2 products.
// s_tready is high only while the sequencer is idle; one item is in work at a time.
// The result sits in an output register; the next item is accepted while it waits,
// and the sequencer holds its finished result until the receiver takes the old one.
// Reset restores register defaults, clears the lock and the stored target, and
// drops m_tvalid.
`default_nettype none
module los_lock_pointing_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // plane_x, plane_y, plane_z, heading, pan, tilt, lock_distance, zero pad
  input  logic [167:0]                s_tdata,
  // op
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // pan_out, tilt_out, range_out, zero pad
  output logic [63:0]                 m_tdata,
  // updated, lock_active
  output logic [1:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lls_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lls_pkg::*;

  function automatic logic signed [CW-1:0] rq30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + RND30;
    return CW'(t >>> 30);
  endfunction

  function automatic logic signed [DW-1:0] rq16(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + RND16;
    return DW'(t >>> 16);
  endfunction

  function automatic logic signed [TW-1:0] sat34(input logic signed [CW:0] v);
    logic signed [TW-1:0] r;
    if (v > (CW+1)'(TGT_MAX_X)) r = TW'(TGT_MAX_X);
    else if (v < (CW+1)'(TGT_MIN_X)) r = TW'(TGT_MIN_X);
    else r = TW'(v);
    return r;
  endfunction

  cfg_t cfg;

  state_t state, state_next;
  logic   launched;
  logic   lock;

  op_t                  op_r;
  logic signed [31:0]   px, py, pz;
  logic [14:0]          hdg;
  logic signed [14:0]   pan_r;
  logic signed [13:0]   tilt_r;
  logic [23:0]          lock_dist;

  logic signed [MB_W-1:0] sh, ch, sp, cp, sa, ca;
  logic signed [CW-1:0]   cx, cy, cz, horiz;
  logic signed [TW-1:0]   te, tu, ts;
  logic signed [DW-1:0]   hx, hmag, tx, tmag;
  logic signed [ZW-1:0]   hang, pang;

  logic                 cor_start, cor_rotate, cor_done;
  logic signed [DW-1:0] cor_xi, cor_yi, cor_x, cor_y;
  logic signed [ZW-1:0] cor_zi, cor_z;
  logic                 mul_start, mul_done;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   step_done;

  logic signed [16:0]   ang_sel;
  rot_arg_t             ra;
  logic signed [DW-1:0] vin_x, vin_y;
  logic signed [CW-1:0] dx, dy, dzn;
  logic signed [MB_W-1:0] rot_s, rot_c;
  logic                 out_free;

  logic signed [DW-1:0] range_w;
  logic [31:0]          rng32;
  logic                 track_ok;
  logic signed [17:0]   pw;
  logic signed [16:0]   tq;
  logic signed [14:0]   pan_o;
  logic signed [13:0]   tilt_o;

  lls_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  lls_cordic u_cordic (
    .clk, .rst, .start(cor_start), .rotate(cor_rotate),
    .x_in(cor_xi), .y_in(cor_yi), .z_in(cor_zi),
    .x(cor_x), .y(cor_y), .z(cor_z), .done(cor_done)
  );

  lls_mult u_mult (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p), .done(mul_done)
  );

  assign step_done = cor_done | mul_done;
  assign out_free = ~m_tvalid | m_tready;

  assign dx = CW'(te) - cx;
  assign dy = CW'(tu) - cy;
  assign dzn = cz - CW'(ts);

  assign ra = reduce_angle(ang_sel);
  assign rot_s = MB_W'(ra.flip ? -cor_y : cor_y);
  assign rot_c = MB_W'(ra.flip ? -cor_x : cor_x);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_ROT_HEAD;
      ST_ROT_HEAD: if (step_done) state_next = ST_MUL_FS;
      ST_MUL_FS: if (step_done) state_next = ST_MUL_FC;
      ST_MUL_FC: begin
        if (step_done) begin
          if (op_r == OP_SET) state_next = ST_ROT_TILT;
          else if (lock && op_r != OP_DISABLE) state_next = ST_VEC_H;
          else state_next = ST_OUT;
        end
      end
      ST_ROT_TILT: if (step_done) state_next = ST_ROT_AIM;
      ST_ROT_AIM: if (step_done) state_next = ST_MUL_HZ;
      ST_MUL_HZ: if (step_done) state_next = ST_MUL_E;
      ST_MUL_E: if (step_done) state_next = ST_MUL_S;
      ST_MUL_S: if (step_done) state_next = ST_MUL_U;
      ST_MUL_U: if (step_done) state_next = ST_VEC_H;
      ST_VEC_H: if (step_done) state_next = ST_MAG_H;
      ST_MAG_H: if (step_done) state_next = ST_VEC_T;
      ST_VEC_T: if (step_done) state_next = ST_MAG_T;
      ST_MAG_T: if (step_done) state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cor_start = 1'b0;
    cor_rotate = 1'b1;
    mul_start = 1'b0;
    ang_sel = $signed({2'b0, hdg});
    vin_x = '0;
    vin_y = '0;
    mul_a = $signed({{(MA_W-16){1'b0}}, cfg.fwd});
    mul_b = sh;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_ROT_HEAD: cor_start = ~launched;
      ST_ROT_TILT: begin
        cor_start = ~launched;
        ang_sel = 17'(tilt_r);
      end
      ST_ROT_AIM: begin
        cor_start = ~launched;
        ang_sel = $signed({2'b0, hdg}) + 17'(pan_r);
      end
      ST_MUL_FS: mul_start = ~launched;
      ST_MUL_FC: begin
        mul_start = ~launched;
        mul_b = ch;
      end
      ST_MUL_HZ: begin
        mul_start = ~launched;
        mul_a = $signed({{(MA_W-24){1'b0}}, lock_dist});
        mul_b = cp;
      end
      ST_MUL_E: begin
        mul_start = ~launched;
        mul_a = MA_W'(horiz);
        mul_b = sa;
      end
      ST_MUL_S: begin
        mul_start = ~launched;
        mul_a = MA_W'(horiz);
        mul_b = ca;
      end
      ST_MUL_U: begin
        mul_start = ~launched;
        mul_a = $signed({{(MA_W-24){1'b0}}, lock_dist});
        mul_b = sp;
      end
      ST_VEC_H: begin
        cor_start = ~launched;
        cor_rotate = 1'b0;
        vin_x = DW'($signed({dzn, 8'b0}));
        vin_y = DW'($signed({dx, 8'b0}));
      end
      ST_MAG_H: begin
        mul_start = ~launched;
        mul_a = hx;
        mul_b = INV_GAIN_Q16;
      end
      ST_VEC_T: begin
        cor_start = ~launched;
        cor_rotate = 1'b0;
        vin_x = hmag;
        vin_y = DW'($signed({dy, 8'b0}));
      end
      ST_MAG_T: begin
        mul_start = ~launched;
        mul_a = tx;
        mul_b = INV_GAIN_Q16;
      end
      default: ;
    endcase
    if (cor_rotate) begin
      cor_xi = INV_GAIN_Q30;
      cor_yi = '0;
      cor_zi = ra.z;
    end else if (vin_x[DW-1]) begin
      cor_xi = -vin_x;
      cor_yi = -vin_y;
      cor_zi = vin_y[DW-1] ? -Z_HALF_TURN : Z_HALF_TURN;
    end else begin
      cor_xi = vin_x;
      cor_yi = vin_y;
      cor_zi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      launched <= 1'b0;
      lock <= 1'b0;
      te <= '0;
      tu <= '0;
      ts <= '0;
    end else begin
      state <= state_next;
      if (cor_start || mul_start) launched <= 1'b1;
      else if (step_done) launched <= 1'b0;
      if (state == ST_MUL_FC && step_done && op_r == OP_DISABLE) lock <= 1'b0;
      if (step_done) begin
        case (state)
          ST_MUL_E: te <= sat34((CW+1)'(cx) + (CW+1)'(rq30(mul_p)));
          ST_MUL_S: ts <= sat34((CW+1)'(cz) - (CW+1)'(rq30(mul_p)));
          ST_MUL_U: begin
            tu <= sat34((CW+1)'(cy) + (CW+1)'(rq30(mul_p)));
            lock <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op_r <= op_t'(s_tuser);
      px <= s_tdata[31:0];
      py <= s_tdata[63:32];
      pz <= s_tdata[95:64];
      hdg <= s_tdata[110:96];
      pan_r <= s_tdata[125:111];
      tilt_r <= s_tdata[139:126];
      lock_dist <= s_tdata[163:140];
    end
    if (step_done) begin
      case (state)
        ST_ROT_HEAD: begin
          sh <= rot_s;
          ch <= rot_c;
        end
        ST_MUL_FS: cx <= CW'(px) + rq30(mul_p);
        ST_MUL_FC: begin
          cz <= CW'(pz) - rq30(mul_p);
          cy <= CW'(py) - $signed({{(CW-16){1'b0}}, cfg.down});
        end
        ST_ROT_TILT: begin
          sp <= rot_s;
          cp <= rot_c;
        end
        ST_ROT_AIM: begin
          sa <= rot_s;
          ca <= rot_c;
        end
        ST_MUL_HZ: horiz <= rq30(mul_p);
        ST_VEC_H: begin
          hx <= cor_x;
          hang <= cor_z;
        end
        ST_MAG_H: hmag <= rq16(mul_p);
        ST_VEC_T: begin
          tx <= cor_x;
          pang <= cor_z;
        end
        ST_MAG_T: tmag <= rq16(mul_p);
        default: ;
      endcase
    end
  end

  always_comb begin
    range_w = (tmag + DW'(128)) >>> 8;
    if (range_w[DW-1]) rng32 = '0;
    else if (range_w[DW-1:32] != '0) rng32 = '1;
    else rng32 = range_w[31:0];
    track_ok = (op_r == OP_TRACK) && !range_w[DW-1] &&
               (range_w >= $signed({{(DW-16){1'b0}}, cfg.min_range}));
    pw = 18'((hang + ZW'(512)) >>> 10) - $signed({3'b0, hdg});
    for (int i = 0; i < 3; i++) begin
      if (pw > P_HALF) pw = pw - P_TURN;
      else if (pw < -P_HALF) pw = pw + P_TURN;
    end
    tq = 17'((pang + ZW'(512)) >>> 10);
    if (tq > 17'(cfg.tilt_hi)) tq = 17'(cfg.tilt_hi);
    if (tq < 17'(cfg.tilt_lo)) tq = 17'(cfg.tilt_lo);
    if (lock && track_ok) begin
      pan_o = 15'(pw);
      tilt_o = 14'(tq);
    end else begin
      pan_o = pan_r;
      tilt_o = tilt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {3'b0, (lock ? rng32 : 32'd0), tilt_o, pan_o};
      m_tuser <= {lock, lock & track_ok};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lls_mult.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle.
`default_nettype none
module lls_mult (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lls_pkg::MA_W-1:0]   a,
  input  logic signed [lls_pkg::MB_W-1:0]   b,
  output logic signed [lls_pkg::PW-1:0]     p,
  output logic                              done
);
  import lls_pkg::*;

  logic                 busy;
  logic [MCNT_W-1:0]    cnt;
  logic signed [PW-1:0] ash;
  logic [MB_W-1:0]      breg;
  logic signed [PW-1:0] term;
  logic                 last;

  assign last = (cnt == MCNT_W'(MB_W - 1));
  assign term = breg[0] ? ash : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p <= '0;
      ash <= PW'(a);
      breg <= b;
    end else if (busy) begin
      // sign bit carries negative weight
      p <= last ? p - term : p + term;
      ash <= ash <<< 1;
      breg <= breg >> 1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lls_cordic.sv -----
// Iterative CORDIC unit for rotation and vectoring, one micro-rotation per cycle.
`default_nettype none
module lls_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            rotate,
  input  logic signed [lls_pkg::DW-1:0]   x_in,
  input  logic signed [lls_pkg::DW-1:0]   y_in,
  input  logic signed [lls_pkg::ZW-1:0]   z_in,
  output logic signed [lls_pkg::DW-1:0]   x,
  output logic signed [lls_pkg::DW-1:0]   y,
  output logic signed [lls_pkg::ZW-1:0]   z,
  output logic                            done
);
  import lls_pkg::*;

  logic                 busy;
  logic                 mode_rot;
  logic [ITER_W-1:0]    idx;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic                 dir;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = atan_tab(5'(idx));
  assign dir = mode_rot ? ~z[ZW-1] : y[DW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      y <= y_in;
      z <= z_in;
      mode_rot <= rotate;
    end else if (busy) begin
      if (dir) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lls_cfg.sv -----
// APB register bank for offsets, minimum range and tilt limits.
`default_nettype none
module lls_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lls_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lls_pkg::cfg_t               cfg
);
  import lls_pkg::*;

  logic [2:0] idx;
  logic       wen;

  assign idx = paddr[ADDR_W-1:2];
  assign wen = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fwd <= 16'd768;
      cfg.down <= 16'd1280;
      cfg.min_range <= 16'd256;
      cfg.tilt_hi <= 14'sd2880;
      cfg.tilt_lo <= -14'sd5760;
    end else if (wen) begin
      case (idx)
        REG_FWD: cfg.fwd <= pwdata[15:0];
        REG_DOWN: cfg.down <= pwdata[15:0];
        REG_MINR: cfg.min_range <= pwdata[15:0];
        REG_TUP: cfg.tilt_hi <= pwdata[13:0];
        REG_TLO: cfg.tilt_lo <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FWD: prdata = {16'b0, cfg.fwd};
      REG_DOWN: prdata = {16'b0, cfg.down};
      REG_MINR: prdata = {16'b0, cfg.min_range};
      REG_TUP: prdata = {{18{cfg.tilt_hi[13]}}, cfg.tilt_hi};
      REG_TLO: prdata = {{18{cfg.tilt_lo[13]}}, cfg.tilt_lo};
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
